FILE: rtl/rme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_pkg
// Shared types and constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package rme_pkg;

    // Width of message, exponent, modulus and result words.
    localparam int WORD_BITS = 32;

    // Steps of one modular product: a doubling step and an add step per bit.
    localparam int MUL_STEPS = 2 * WORD_BITS;
    localparam int STEP_W    = $clog2(MUL_STEPS);

    // Exponent bit counter, wide enough to hold WORD_BITS itself.
    localparam int EBIT_W = $clog2(WORD_BITS + 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = CFG_IDX_W'(1);

    // Register reset values.
    localparam logic [WORD_BITS-1:0] EXPONENT_RST = WORD_BITS'(65537);
    localparam logic [WORD_BITS-1:0] MODULUS_RST  = WORD_BITS'(1);

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_GO,
        ST_RED_WAIT,
        ST_EXP_GO,
        ST_EXP_WAIT,
        ST_DONE
    } t_state;

endpackage

FILE: rtl/rsa_modular_exponentiation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_modular_exponentiation
// Computes message_word ^ exponent mod modulus by right-to-left binary
// square-and-multiply with two bit-serial modular multipliers.
// ----------------------------------------------------------------------------
// One request is taken when start is high and busy is low; busy then stays
// high until the result has been shown. The message is first reduced modulo
// the modulus in one pass of a multiplier, then each of the WORD_BITS
// exponent bits runs the square and the multiply side by side in two
// bit-serial multipliers. A pass runs 2*WORD_BITS multiplier steps, and
// every request runs all WORD_BITS exponent passes whatever the exponent
// value. No new request is taken while one is in progress; after the result
// strobe the block returns to idle, where the next request can be accepted.
// The result is on o_result_word in the one cycle in which o_done is high;
// the receiver cannot stall it. Exponent and modulus are written through
// the configuration channel, which is always ready, and must only be
// written while busy is low. A modulus of zero gives a result of zero.
// ----------------------------------------------------------------------------
module rsa_modular_exponentiation
    import rme_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [WORD_BITS-1:0] i_message_word,
    output logic                 o_done,
    output logic [WORD_BITS-1:0] o_result_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_BITS-1:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [WORD_BITS-1:0] r_exponent;
    logic [WORD_BITS-1:0] r_modulus;
    logic [WORD_BITS-1:0] r_msg;
    logic [WORD_BITS-1:0] r_exp_sh;
    logic [WORD_BITS-1:0] r_base;
    logic [WORD_BITS-1:0] r_acc;
    logic [EBIT_W-1:0]    r_ebit;

    logic                 mul_go;
    logic [WORD_BITS-1:0] one_mod;
    logic [WORD_BITS-1:0] mul0_a;
    logic [WORD_BITS-1:0] mul0_b;
    logic                 mul0_done;
    logic                 mul1_done;
    logic [WORD_BITS-1:0] mul0_p;
    logic [WORD_BITS-1:0] mul1_p;

    // Configuration registers; the channel never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= EXPONENT_RST;
            r_modulus  <= MODULUS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_EXPONENT: r_exponent <= i_cfg_data;
                CFG_MODULUS:  r_modulus  <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // The value 1 reduced modulo the modulus.
    assign one_mod = (r_modulus == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);

    // Multiplier 0 reduces the message (1 * msg), then forms acc * base.
    // Multiplier 1 squares the base.
    assign mul0_a = (r_state == ST_RED_GO || r_state == ST_RED_WAIT) ? one_mod : r_acc;
    assign mul0_b = (r_state == ST_RED_GO || r_state == ST_RED_WAIT) ? r_msg : r_base;

    rme_modmul u_mul_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_go),
        .i_a       (mul0_a),
        .i_b       (mul0_b),
        .i_m       (r_modulus),
        .o_done    (mul0_done),
        .o_product (mul0_p)
    );

    rme_modmul u_mul_sq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_go),
        .i_a       (r_base),
        .i_b       (r_base),
        .i_m       (r_modulus),
        .o_done    (mul1_done),
        .o_product (mul1_p)
    );

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and control outputs.
    always_comb begin
        n_state = r_state;
        mul_go  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_RED_GO;
                end
            end
            ST_RED_GO: begin
                mul_go  = 1'b1;
                n_state = ST_RED_WAIT;
            end
            ST_RED_WAIT: begin
                if (mul0_done) begin
                    n_state = ST_EXP_GO;
                end
            end
            ST_EXP_GO: begin
                mul_go  = 1'b1;
                n_state = ST_EXP_WAIT;
            end
            ST_EXP_WAIT: begin
                if (mul0_done) begin
                    if (r_ebit == EBIT_W'(WORD_BITS - 1)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_EXP_GO;
                    end
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Exponent bit counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ebit <= '0;
        end else if (r_state == ST_IDLE) begin
            r_ebit <= '0;
        end else if (r_state == ST_EXP_WAIT && mul0_done) begin
            r_ebit <= r_ebit + EBIT_W'(1);
        end
    end

    // Datapath registers: message, exponent shifter, base and accumulator.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_msg    <= i_message_word;
            r_exp_sh <= r_exponent;
        end
        if (r_state == ST_RED_WAIT && mul0_done) begin
            r_base <= mul0_p;
            r_acc  <= one_mod;
        end
        if (r_state == ST_EXP_WAIT && mul0_done) begin
            if (r_exp_sh[0]) begin
                r_acc <= mul0_p;
            end
            r_base   <= mul1_p;
            r_exp_sh <= {1'b0, r_exp_sh[WORD_BITS-1:1]};
        end
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_done        = (r_state == ST_DONE);
    assign o_result_word = (r_modulus == '0) ? '0 : r_acc;

    // The result strobe lasts one cycle and returns the block to idle.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!o_done && !busy))
        else $error("result strobe not followed by idle");

    // An accepted request makes the block busy on the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // Both multipliers finish together during the exponent loop.
    a_mul_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXP_WAIT) |-> (mul0_done == mul1_done))
        else $error("multipliers out of step");

    // The exponent bit counter never runs past the word width.
    a_ebit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ebit <= EBIT_W'(WORD_BITS))
        else $error("exponent bit counter out of range");

endmodule

FILE: rtl/rme_modmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_modmul
// Bit-serial interleaved modular multiplier: (a * b) mod m, with a < m.
// The multiplier b is shifted out MSB first; each bit takes a doubling step
// and an add step, each a single add-and-reduce of the accumulator.
// ----------------------------------------------------------------------------
module rme_modmul
    import rme_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WORD_BITS-1:0] i_a,
    input  logic [WORD_BITS-1:0] i_b,
    input  logic [WORD_BITS-1:0] i_m,
    output logic                 o_done,
    output logic [WORD_BITS-1:0] o_product
);

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_W-1:0]    r_step;
    logic [WORD_BITS-1:0] r_acc;
    logic [WORD_BITS-1:0] r_b;

    logic [WORD_BITS-1:0] n_acc;
    logic [WORD_BITS-1:0] addend;
    logic [WORD_BITS:0]   sum;
    logic [WORD_BITS+1:0] diff;

    // Even steps double the accumulator, odd steps add a when the bit is set.
    // Both operands are below m, so one conditional subtract reduces the sum.
    always_comb begin
        if (!r_step[0]) begin
            addend = r_acc;
        end else begin
            addend = r_b[WORD_BITS-1] ? i_a : '0;
        end
        sum   = {1'b0, r_acc} + {1'b0, addend};
        diff  = {1'b0, sum} - {2'b00, i_m};
        n_acc = diff[WORD_BITS+1] ? sum[WORD_BITS-1:0] : diff[WORD_BITS-1:0];
    end

    // Step counter and control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Accumulator and multiplier shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            if (r_step[0]) begin
                r_b <= {r_b[WORD_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule
